FILE: rtl/krit_pkg.sv
// ----------------------------------------------------------------------------
// krit_pkg
// Shared constants and types for the keyframe ring invalidate/trim block.
// ----------------------------------------------------------------------------
`default_nettype none

package krit_pkg;

    localparam int RING_DEPTH_DEF = 256;
    localparam int FRAME_BITS_DEF = 31;

    // Input and output stream widths
    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    localparam int SPAN_W  = 16;
    localparam int VOID_CNT_W = 8;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_SET   = 2'd1,
        OP_INVAL = 2'd2,
        OP_RESET = 2'd3
    } krit_op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_VHEAD,
        S_VCHECK,
        S_TSTART,
        S_TCHECK,
        S_OUT
    } krit_state_t;

endpackage

`default_nettype wire

FILE: rtl/keyframe_ring_invalidate_trim.sv
// ----------------------------------------------------------------------------
// keyframe_ring_invalidate_trim
// Record ring with write, set, reset and invalidate-then-trim operations.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Records live in a single
// synchronous RAM (one write port, one read port, registered read data);
// every operation is run by a sequencer that touches one record per cycle.
// Reset clears the ring start and count; write and set first take the
// index modulo RING_DEPTH by repeated subtraction (none when RING_DEPTH is
// 256 or more). Invalidate reads the head record, then the voiding scan
// checks the records after it and the trim visits records from the ring
// start, all through the single RAM read port. The result then loads the
// output register, which may hold one result while the next transaction
// is accepted. Records are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_ring_invalidate_trim
    import krit_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // entry_index[7:0], start_frame[38:8], frame_span[54:39], is_keyframe[55],
    // is_void[56], new_first[64:57], new_count[73:65], zero fill
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[1:0]
    input  wire logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // ring_start_out[7:0], ring_count_out[16:8], voided_records[24:17],
    // no_live_keyframe[25], zero fill
    output logic [OUT_TDATA_W-1:0]      m_tdata
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int POS_W = IDX_W + 1;
    localparam int HI_W  = ((FRAME_BITS > SPAN_W) ? FRAME_BITS : SPAN_W) + 1;
    localparam int REC_W = FRAME_BITS + SPAN_W + 2;

    // Record layout: start frame | span | void | keyframe
    logic [REC_W-1:0] mem [RING_DEPTH];
    logic [REC_W-1:0] mem_rdata;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [REC_W-1:0] mem_wdata;

    krit_state_t state_reg, state_next;
    krit_op_t    op_reg, op_next;
    logic [IDX_W-1:0]      ring_start_reg, ring_start_next;
    logic [CNT_W-1:0]      ring_count_reg, ring_count_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [7:0]            red_reg, red_next;
    logic [7:0]            ent_reg, ent_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [SPAN_W-1:0]     span_reg, span_next;
    logic                  key_reg, key_next;
    logic                  void_reg, void_next;
    logic [CNT_W-1:0]      setcnt_reg, setcnt_next;
    logic [HI_W-1:0]       hi_reg, hi_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [IDX_W-1:0]      tidx_reg, tidx_next;
    logic [CNT_W-1:0]      drop_reg, drop_next;
    logic [VOID_CNT_W-1:0] voided_reg, voided_next;
    logic                  none_reg, none_next;

    // Decoded fields
    logic [1:0]            in_op;
    logic [7:0]            in_entry;
    logic [30:0]           in_start;
    logic [SPAN_W-1:0]     in_span;
    logic                  in_key;
    logic                  in_void;
    logic [7:0]            in_first;
    logic [8:0]            in_count;
    logic [31:0]           in_start_wide;
    logic [CNT_W-1:0]      in_count_sat;

    logic [FRAME_BITS-1:0] rd_frame;
    logic [SPAN_W-1:0]     rd_span;
    logic                  rd_void;
    logic                  rd_key;

    logic [POS_W-1:0]      pos_head;
    logic [POS_W-1:0]      pos_inc;
    logic                  head_cont;
    logic                  inc_cont;
    logic [CNT_W-1:0]      drop_inc;
    logic [31:0]           start_wide;
    logic [31:0]           count_wide;

    assign in_op    = s_tuser[1:0];
    assign in_entry = s_tdata[7:0];
    assign in_start = s_tdata[38:8];
    assign in_span  = s_tdata[54:39];
    assign in_key   = s_tdata[55];
    assign in_void  = s_tdata[56];
    assign in_first = s_tdata[64:57];
    assign in_count = s_tdata[73:65];

    assign in_start_wide = {1'b0, in_start};
    assign in_count_sat  = (32'(in_count) > 32'(RING_DEPTH)) ? CNT_W'(RING_DEPTH)
                                                           : CNT_W'(in_count);

    assign rd_frame = mem_rdata[REC_W-1 -: FRAME_BITS];
    assign rd_span  = mem_rdata[SPAN_W+1:2];
    assign rd_void  = mem_rdata[1];
    assign rd_key   = mem_rdata[0];

    assign pos_head  = POS_W'(ent_reg) + POS_W'(1);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign head_cont = (32'(pos_head) < 32'(ring_count_reg))
                       && (32'(pos_head) < 32'(RING_DEPTH));
    assign inc_cont  = (32'(pos_inc) < 32'(ring_count_reg))
                       && (32'(pos_inc) < 32'(RING_DEPTH));
    assign drop_inc  = drop_reg + CNT_W'(1);

    assign start_wide = 32'(ring_start_reg);
    assign count_wide = 32'(ring_count_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Record RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ring_start_reg <= '0;
            ring_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ring_start_reg <= ring_start_next;
            ring_count_reg <= ring_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        m_tdata_reg <= m_tdata_next;
        red_reg     <= red_next;
        ent_reg     <= ent_next;
        frame_reg   <= frame_next;
        span_reg    <= span_next;
        key_reg     <= key_next;
        void_reg    <= void_next;
        setcnt_reg  <= setcnt_next;
        hi_reg      <= hi_next;
        pos_reg     <= pos_next;
        tidx_reg    <= tidx_next;
        drop_reg    <= drop_next;
        voided_reg  <= voided_next;
        none_reg    <= none_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ring_start_next = ring_start_reg;
        ring_count_next = ring_count_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        red_next        = red_reg;
        ent_next        = ent_reg;
        frame_next      = frame_reg;
        span_next       = span_reg;
        key_next        = key_reg;
        void_next       = void_reg;
        setcnt_next     = setcnt_reg;
        hi_next         = hi_reg;
        pos_next        = pos_reg;
        tidx_next       = tidx_reg;
        drop_next       = drop_reg;
        voided_next     = voided_reg;
        none_next       = none_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = '0;
        s_tready        = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = krit_op_t'(in_op);
                    ent_next    = in_entry;
                    frame_next  = in_start_wide[FRAME_BITS-1:0];
                    span_next   = in_span;
                    key_next    = in_key;
                    void_next   = in_void;
                    setcnt_next = in_count_sat;
                    voided_next = '0;
                    none_next   = 1'b0;
                    case (krit_op_t'(in_op))
                        OP_WRITE:
                        begin
                            red_next   = in_entry;
                            state_next = S_REDUCE;
                        end
                        OP_SET:
                        begin
                            red_next   = in_first;
                            state_next = S_REDUCE;
                        end
                        OP_INVAL:
                        begin
                            // Start index past the ring skips the voiding scan
                            if (32'(in_entry) >= 32'(RING_DEPTH))
                            begin
                                state_next = S_TSTART;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = IDX_W'(in_entry);
                                state_next = S_VHEAD;
                            end
                        end
                        default:
                        begin
                            ring_start_next = '0;
                            ring_count_next = '0;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end

            S_REDUCE:
            begin
                // Take the index modulo the depth by repeated subtraction
                if (32'(red_reg) >= 32'(RING_DEPTH))
                begin
                    red_next = red_reg - 8'(RING_DEPTH);
                end
                else
                begin
                    if (op_reg == OP_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(red_reg);
                        mem_wdata = {frame_reg, span_reg, void_reg, key_reg};
                    end
                    else
                    begin
                        ring_start_next = IDX_W'(red_reg);
                        ring_count_next = setcnt_reg;
                    end
                    state_next = S_OUT;
                end
            end

            S_VHEAD:
            begin
                if (rd_span == '0)
                begin
                    state_next = S_TSTART;
                end
                else
                begin
                    hi_next  = HI_W'(rd_frame) + HI_W'(rd_span) - HI_W'(1);
                    pos_next = pos_head;
                    if (head_cont)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = IDX_W'(pos_head);
                        state_next = S_VCHECK;
                    end
                    else
                    begin
                        state_next = S_TSTART;
                    end
                end
            end

            S_VCHECK:
            begin
                if (HI_W'(rd_frame) > hi_reg)
                begin
                    state_next = S_TSTART;
                end
                else
                begin
                    if (!rd_void)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(pos_reg);
                        mem_wdata = mem_rdata | REC_W'(2);
                        if (voided_reg != '1)
                        begin
                            voided_next = voided_reg + VOID_CNT_W'(1);
                        end
                    end
                    // Read the next record while writing back this one
                    if (inc_cont)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = IDX_W'(pos_inc);
                        pos_next  = pos_inc;
                    end
                    else
                    begin
                        state_next = S_TSTART;
                    end
                end
            end

            S_TSTART:
            begin
                if (ring_count_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ring_start_reg;
                    tidx_next  = ring_start_reg;
                    drop_next  = '0;
                    state_next = S_TCHECK;
                end
            end

            S_TCHECK:
            begin
                if (!rd_void && rd_key)
                begin
                    ring_start_next = tidx_reg;
                    ring_count_next = ring_count_reg - drop_reg;
                    state_next      = S_OUT;
                end
                else if (drop_inc >= ring_count_reg)
                begin
                    // Nothing live: leave the ring as it was
                    none_next  = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    drop_next = drop_inc;
                    if (tidx_reg == IDX_W'(RING_DEPTH - 1))
                    begin
                        tidx_next = '0;
                        mem_raddr = '0;
                    end
                    else
                    begin
                        tidx_next = tidx_reg + IDX_W'(1);
                        mem_raddr = tidx_reg + IDX_W'(1);
                    end
                    mem_re = 1'b1;
                end
            end

            S_OUT:
            begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, none_reg, voided_reg,
                                     count_wide[8:0], start_wide[7:0]};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
